### rtl/upsc_pkg.sv
// Package for the integer pixel upscaler: limits, field widths, register
// indexes and the structs passed between the front, queue, back and config units.
// No dependencies.
package upsc_pkg;

  localparam int MAX_SCALE      = 8;
  localparam int MAX_SRC_DIM    = 1024;
  localparam int MAX_SCREEN_DIM = 4096;

  localparam int PIX_W  = 32;
  localparam int ADDR_W = 24;
  localparam int SRC_W  = 11;
  localparam int SCL_W  = 4;
  localparam int SCR_W  = 13;

  localparam int NUM_REGS = 8;
  localparam int IDX_W    = $clog2(NUM_REGS);
  localparam int PADDR_W  = IDX_W + 2;
  localparam int PDATA_W  = 32;

  localparam int SC_W    = $clog2(MAX_SCALE + 1);
  localparam int WC_W    = $clog2(MAX_SRC_DIM + 1);
  localparam int SW_W    = $clog2(MAX_SCREEN_DIM + 1);
  localparam int CNT_W   = $clog2(MAX_SRC_DIM);
  localparam int UV_W    = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int OFF_W   = $clog2(MAX_SCREEN_DIM / 2);
  localparam int SPAN_W  = $clog2(MAX_SRC_DIM * MAX_SCALE + 1);
  localparam int POS_MAX = (MAX_SCREEN_DIM - 1) / 2 + (MAX_SRC_DIM - 1) * MAX_SCALE
                           + MAX_SCALE - 1;
  localparam int POS_W   = $clog2(POS_MAX + 1);
  localparam int MUL_W   = POS_W + SCR_W;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [IDX_W-1:0] {
    REG_SRC_WIDTH     = 3'd0,
    REG_SRC_HEIGHT    = 3'd1,
    REG_SCALE         = 3'd2,
    REG_SCREEN_WIDTH  = 3'd3,
    REG_SCREEN_HEIGHT = 3'd4,
    REG_ROW_PITCH     = 3'd5,
    REG_CENTER_ENABLE = 3'd6,
    REG_WIDE_PIXELS   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [SC_W-1:0]  scale;
    logic [WC_W-1:0]  width;
    logic [WC_W-1:0]  height;
    logic [SW_W-1:0]  scr_w;
    logic [SW_W-1:0]  scr_h;
    logic [SCR_W-1:0] pitch;
    logic [OFF_W-1:0] off_x;
    logic [OFF_W-1:0] off_y;
    logic             wide;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] base_x;
    logic [POS_W-1:0] base_y;
    logic [PIX_W-1:0] pix;
  } qent_t;

  typedef struct packed {
    logic             s1_valid;
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
  } front_sts_t;

  typedef struct packed {
    logic [QPTR_W:0] count;
    logic            full;
    logic            empty;
  } queue_sts_t;

  typedef struct packed {
    logic            busy;
    logic [UV_W-1:0] u;
    logic [UV_W-1:0] v;
  } back_sts_t;

endpackage

### rtl/upsc_in_if.sv
// Source pixel request channel: valid/ready handshake with pixel payload.
// Depends on upsc_pkg.
interface upsc_in_if
  import upsc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             frame_start;

  modport source (output valid, output pixel_in, output frame_start, input ready);
  modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

### rtl/upsc_out_if.sv
// Framebuffer write request channel: valid/ready handshake with write payload.
// Depends on upsc_pkg.
interface upsc_out_if
  import upsc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] write_address;
  logic [PIX_W-1:0]  pixel_out;
  logic              outside_screen;
  logic              last_of_run;

  modport source (output valid, output write_address, output pixel_out,
                  output outside_screen, output last_of_run, input ready);
  modport sink   (input valid, input write_address, input pixel_out,
                  input outside_screen, input last_of_run, output ready);
endinterface

### rtl/upsc_cfg.sv
// APB-style register file for the upscaler, with clamped settings and
// registered centering offsets. Depends on upsc_pkg.
module upsc_cfg
  import upsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [SRC_W-1:0] src_width_r, src_height_r;
  logic [SCL_W-1:0] scale_r;
  logic [SCR_W-1:0] screen_width_r, screen_height_r, row_pitch_r;
  logic             center_enable_r, wide_pixels_r;
  logic [OFF_W-1:0] off_x_r, off_y_r, off_x_nxt, off_y_nxt;

  logic [SC_W-1:0]   s_c;
  logic [WC_W-1:0]   w_c, h_c;
  logic [SW_W-1:0]   sw_c, sh_c;
  logic [SPAN_W-1:0] scaled_x, scaled_y;
  logic [SPAN_W:0]   diff_x, diff_y;
  reg_idx_t          idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r     <= SRC_W'(320);
      src_height_r    <= SRC_W'(240);
      scale_r         <= SCL_W'(2);
      screen_width_r  <= SCR_W'(640);
      screen_height_r <= SCR_W'(480);
      row_pitch_r     <= SCR_W'(640);
      center_enable_r <= 1'b0;
      wide_pixels_r   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_SRC_WIDTH:     src_width_r     <= pwdata[SRC_W-1:0];
        REG_SRC_HEIGHT:    src_height_r    <= pwdata[SRC_W-1:0];
        REG_SCALE:         scale_r         <= pwdata[SCL_W-1:0];
        REG_SCREEN_WIDTH:  screen_width_r  <= pwdata[SCR_W-1:0];
        REG_SCREEN_HEIGHT: screen_height_r <= pwdata[SCR_W-1:0];
        REG_ROW_PITCH:     row_pitch_r     <= pwdata[SCR_W-1:0];
        REG_CENTER_ENABLE: center_enable_r <= pwdata[0];
        REG_WIDE_PIXELS:   wide_pixels_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SRC_WIDTH:     prdata = PDATA_W'(src_width_r);
      REG_SRC_HEIGHT:    prdata = PDATA_W'(src_height_r);
      REG_SCALE:         prdata = PDATA_W'(scale_r);
      REG_SCREEN_WIDTH:  prdata = PDATA_W'(screen_width_r);
      REG_SCREEN_HEIGHT: prdata = PDATA_W'(screen_height_r);
      REG_ROW_PITCH:     prdata = PDATA_W'(row_pitch_r);
      REG_CENTER_ENABLE: prdata = PDATA_W'(center_enable_r);
      REG_WIDE_PIXELS:   prdata = PDATA_W'(wide_pixels_r);
      default:           prdata = '0;
    endcase
  end

  // Clamp settings into their legal ranges
  always_comb begin
    if (scale_r == '0) s_c = SC_W'(1);
    else if (32'(scale_r) > MAX_SCALE) s_c = SC_W'(MAX_SCALE);
    else s_c = SC_W'(scale_r);

    if (src_width_r == '0) w_c = WC_W'(1);
    else if (32'(src_width_r) > MAX_SRC_DIM) w_c = WC_W'(MAX_SRC_DIM);
    else w_c = WC_W'(src_width_r);

    if (src_height_r == '0) h_c = WC_W'(1);
    else if (32'(src_height_r) > MAX_SRC_DIM) h_c = WC_W'(MAX_SRC_DIM);
    else h_c = WC_W'(src_height_r);

    if (32'(screen_width_r) > MAX_SCREEN_DIM) sw_c = SW_W'(MAX_SCREEN_DIM);
    else sw_c = SW_W'(screen_width_r);

    if (32'(screen_height_r) > MAX_SCREEN_DIM) sh_c = SW_W'(MAX_SCREEN_DIM);
    else sh_c = SW_W'(screen_height_r);
  end

  // Centering offsets: (screen - scaled) / 2, zero when disabled or too large
  always_comb begin
    scaled_x = SPAN_W'(w_c) * SPAN_W'(s_c);
    scaled_y = SPAN_W'(h_c) * SPAN_W'(s_c);
    diff_x   = (SPAN_W+1)'(sw_c) - (SPAN_W+1)'(scaled_x);
    diff_y   = (SPAN_W+1)'(sh_c) - (SPAN_W+1)'(scaled_y);
    if (center_enable_r && (32'(sw_c) > 32'(scaled_x))) off_x_nxt = diff_x[OFF_W:1];
    else off_x_nxt = '0;
    if (center_enable_r && (32'(sh_c) > 32'(scaled_y))) off_y_nxt = diff_y[OFF_W:1];
    else off_y_nxt = '0;
  end

  always_ff @(posedge clk) begin
    off_x_r <= off_x_nxt;
    off_y_r <= off_y_nxt;
  end

  always_comb begin
    cfg.scale = s_c;
    cfg.width = w_c;
    cfg.height = h_c;
    cfg.scr_w = sw_c;
    cfg.scr_h = sh_c;
    cfg.pitch = row_pitch_r;
    cfg.off_x = off_x_r;
    cfg.off_y = off_y_r;
    cfg.wide  = wide_pixels_r;
  end

endmodule

### rtl/upsc_front.sv
// Front unit: accepts source pixels, tracks column and row, masks narrow
// pixels and computes the block origin for the queue. Depends on upsc_pkg, upsc_in_if.
module upsc_front
  import upsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  upsc_in_if.sink     in_ch,
  input  cfg_t        cfg,
  input  logic        q_full,
  output logic        q_push,
  output qent_t       q_wdata,
  output front_sts_t  sts
);

  logic             s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0] s1_pix_r;
  logic [CNT_W-1:0] s1_col_r, s1_row_r;
  logic [CNT_W-1:0] col_r, row_r, col_nxt, row_nxt, col_cur, row_cur;
  logic [CNT_W:0]   col_inc, row_inc;
  logic             accept;
  logic [CNT_W+SC_W-1:0] prod_x, prod_y;

  assign q_push      = s1_valid_r && !q_full;
  assign in_ch.ready = !s1_valid_r || !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    col_cur = in_ch.frame_start ? '0 : col_r;
    row_cur = in_ch.frame_start ? '0 : row_r;
    col_inc = (CNT_W+1)'(col_cur) + (CNT_W+1)'(1);
    row_inc = (CNT_W+1)'(row_cur) + (CNT_W+1)'(1);
    if (32'(col_inc) >= 32'(cfg.width)) begin
      col_nxt = '0;
      row_nxt = (32'(row_inc) >= 32'(cfg.height)) ? '0 : row_inc[CNT_W-1:0];
    end else begin
      col_nxt = col_inc[CNT_W-1:0];
      row_nxt = row_cur;
    end
    s1_valid_nxt = accept ? 1'b1 : (q_push ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r <= cfg.wide ? in_ch.pixel_in : {16'd0, in_ch.pixel_in[15:0]};
      s1_col_r <= col_cur;
      s1_row_r <= row_cur;
    end
  end

  always_comb begin
    prod_x         = (CNT_W+SC_W)'(s1_col_r) * (CNT_W+SC_W)'(cfg.scale);
    prod_y         = (CNT_W+SC_W)'(s1_row_r) * (CNT_W+SC_W)'(cfg.scale);
    q_wdata.base_x = POS_W'(cfg.off_x) + POS_W'(prod_x);
    q_wdata.base_y = POS_W'(cfg.off_y) + POS_W'(prod_y);
    q_wdata.pix    = s1_pix_r;
  end

  assign sts = '{s1_valid: s1_valid_r, col: s1_col_r, row: s1_row_r};

endmodule

### rtl/upsc_queue.sv
// Short request queue between the front and back units.
// Depends on upsc_pkg.
module upsc_queue
  import upsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  qent_t      wdata,
  input  logic       pop,
  output qent_t      rdata,
  output queue_sts_t sts
);

  qent_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + (QPTR_W+1)'(1);
        2'b01:   count_r <= count_r - (QPTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign rdata     = mem_r[rd_ptr_r];
  assign sts.count = count_r;
  assign sts.full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign sts.empty = (count_r == '0);

endmodule

### rtl/upsc_back.sv
// Back unit: replicates each queued pixel into a scale x scale block of
// framebuffer write requests behind an output register. Depends on upsc_pkg, upsc_out_if.
module upsc_back
  import upsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  qent_t       q_rdata,
  input  logic        q_empty,
  output logic        q_pop,
  upsc_out_if.source  out_ch,
  output back_sts_t   sts
);

  logic              busy_r, busy_nxt;
  logic [POS_W-1:0]  bx_r, by_r;
  logic [PIX_W-1:0]  pix_r;
  logic [UV_W-1:0]   u_r, v_r, u_nxt, v_nxt, s_max;
  logic              step, last, load;
  logic [POS_W-1:0]  x, y;
  logic [MUL_W-1:0]  addr_full;

  logic              ovalid_r, ovalid_nxt;
  logic [ADDR_W-1:0] oaddr_r;
  logic [PIX_W-1:0]  opix_r;
  logic              oout_r, olast_r;

  assign s_max = UV_W'(cfg.scale - SC_W'(1));
  assign step  = busy_r && (!ovalid_r || out_ch.ready);
  assign last  = (u_r == s_max) && (v_r == s_max);
  assign load  = !q_empty && (!busy_r || (step && last));
  assign q_pop = load;

  always_comb begin
    x         = bx_r + POS_W'(u_r);
    y         = by_r + POS_W'(v_r);
    addr_full = MUL_W'(y) * MUL_W'(cfg.pitch) + MUL_W'(x);

    u_nxt = u_r;
    v_nxt = v_r;
    if (load) begin
      u_nxt = '0;
      v_nxt = '0;
    end else if (step) begin
      if (u_r == s_max) begin
        u_nxt = '0;
        v_nxt = v_r + UV_W'(1);
      end else begin
        u_nxt = u_r + UV_W'(1);
      end
    end

    busy_nxt   = load ? 1'b1 : ((step && last) ? 1'b0 : busy_r);
    ovalid_nxt = step ? 1'b1 : (out_ch.ready ? 1'b0 : ovalid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
      u_r      <= '0;
      v_r      <= '0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
      u_r      <= u_nxt;
      v_r      <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bx_r  <= q_rdata.base_x;
      by_r  <= q_rdata.base_y;
      pix_r <= q_rdata.pix;
    end
    if (step) begin
      oaddr_r <= addr_full[ADDR_W-1:0];
      opix_r  <= pix_r;
      oout_r  <= (32'(x) >= 32'(cfg.scr_w)) || (32'(y) >= 32'(cfg.scr_h));
      olast_r <= last;
    end
  end

  assign out_ch.valid          = ovalid_r;
  assign out_ch.write_address  = oaddr_r;
  assign out_ch.pixel_out      = opix_r;
  assign out_ch.outside_screen = oout_r;
  assign out_ch.last_of_run    = olast_r;

  assign sts = '{busy: busy_r, u: u_r, v: v_r};

endmodule

### rtl/integer_pixel_upscaler.sv
// Top level of the integer pixel upscaler: config registers, front unit,
// request queue and back unit. Depends on upsc_pkg, upsc_in_if, upsc_out_if and all units.
//
//  channel  | direction | handshake             | payload
//  in_ch    | in        | valid/ready           | pixel_in[31:0], frame_start
//  out_ch   | out       | valid/ready           | write_address[23:0], pixel_out[31:0],
//           |           |                       | outside_screen, last_of_run
//  cfg      | in        | psel/penable/pwrite   | paddr[4:0], pwdata/prdata[31:0]
//
// Each source pixel becomes scale*scale write requests: the back unit issues one write
// request per cycle from its block counters while out_ch.ready does not hold it.
// The front takes one pixel per cycle until the 4-entry queue fills.
// Reset is synchronous: registers return to defaults, position to (0,0), queue empties.
// A low out_ch.ready holds the back unit; in_ch.ready drops while the queue is full
// and the front stage holds a request.
module integer_pixel_upscaler
  import upsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  upsc_in_if.sink            in_ch,
  upsc_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t       cfg;
  qent_t      q_wdata, q_rdata;
  logic       q_push, q_pop;
  queue_sts_t q_sts;
  front_sts_t f_sts;
  back_sts_t  b_sts;

  upsc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  upsc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg),
    .q_full  (q_sts.full),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .sts     (f_sts)
  );

  upsc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .sts   (q_sts)
  );

  upsc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_rdata (q_rdata),
    .q_empty (q_sts.empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .sts     (b_sts)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(q_sts.count) <= QDEPTH)
    else $error("request queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_sts.empty)
    else $error("pop from empty request queue");

  a_frame_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.frame_start) |=>
      (f_sts.s1_valid && f_sts.col == '0 && f_sts.row == '0))
    else $error("frame start did not place pixel at origin");

  a_idle_uv: assert property (@(posedge clk) disable iff (!rst_n)
    (!b_sts.busy && !$past(b_sts.busy)) |->
      (b_sts.u == $past(b_sts.u) && b_sts.v == $past(b_sts.v)))
    else $error("block counters moved while back unit idle");

endmodule
